// ===== hdl/gic_pkg.sv =====
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gamepad input conditioner
// Holds the poll record, the result record, the state types and the sizes.
// ----------------------------------------------------------------------------
package gic_pkg;

	localparam int NUM_PADS    = 4;
	localparam int NUM_BUTTONS = 16;
	localparam int PAD_W       = 2;
	localparam int BTN_W       = 4;
	localparam int SLOT_W      = PAD_W + BTN_W;
	localparam int SLOTS       = NUM_PADS * NUM_BUTTONS;
	localparam int CNT_W       = 24;

	localparam logic [7:0]  RST_TRIG_DZ  = 8'd6;
	localparam logic [14:0] RST_STICK_DZ = 15'd7864;
	localparam logic [7:0]  RST_PRESS_M  = 8'd32;
	localparam logic [7:0]  RST_REL_M    = 8'd64;

	typedef enum logic [1:0] {
		CFG_TRIG_DZ  = 2'd0,
		CFG_STICK_DZ = 2'd1,
		CFG_PRESS_M  = 2'd2,
		CFG_REL_M    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PAD_W-1:0]   pad;
		logic               valid;
		logic               pad_ok;
		logic [13:0]        mask;
		logic [7:0]         trig0;
		logic [7:0]         trig1;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [6:0]         elapsed;
	} poll_t;

	typedef struct packed {
		logic [PAD_W-1:0]   pad;
		logic               conn;
		logic [BTN_W-1:0]   bidx;
		logic [7:0]         frames;
		logic [15:0]        ms;
		logic [7:0]         lt;
		logic [7:0]         rt;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [14:0] stick_dz;
		logic [7:0]  press_m;
		logic [7:0]  rel_m;
	} back_cfg_t;

	typedef enum logic [2:0] {
		B_IDLE, B_LGO, B_LWT, B_RGO, B_RWT, B_RD, B_UPD, B_OUT
	} back_state_t;

	typedef enum logic [3:0] {
		STK_IDLE, STK_SQX, STK_SQY, STK_CHK, STK_ROOT, STK_SEL, STK_DIV, STK_MUL, STK_DONE
	} stk_state_t;

	typedef enum logic [1:0] {
		PH_G, PH_X, PH_Y
	} stk_phase_t;

endpackage

// ===== hdl/gamepad_input_conditioner.sv =====
// ----------------------------------------------------------------------------
// gamepad_input_conditioner: pad poll conditioning top level
//
// Channel  Direction  Contents
// s_*      in         one poll request of one pad
// m_*      out        sixteen button results per poll, tlast on the last
// cfg_*    in         register writes, no read-back
//
// A poll of a connected pad runs both sticks through the back end. Each
// stick takes a square root and three passes of the shared bit-serial
// divider. A stick beyond full scale needs two passes and a stick inside
// the dead zone skips the root and the divider. Each of the sixteen results
// then goes through read, update and output states and can be held by an
// output stall. A disconnected pad skips the sticks. The front queue holds
// two polls, so input requests are still taken while it has room and the
// back end works or is stalled.
// Reset is asynchronous; hold counters read as zero until first written.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pad_index, pad_connected, button_mask, left_trigger_raw,
	// right_trigger_raw, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
	// elapsed_ms
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_pad, out_connected, button_number, held_frames, held_ms,
	// left_trigger, right_trigger, left_x, left_y, right_x, right_y, zero
	output logic [111:0] m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data
);
	import gic_pkg::*;

	logic [7:0]  trig_dz_q;
	back_cfg_t   cfg_q;
	logic        q_vld;
	logic        q_rdy;
	poll_t       q_rec;
	res_t        res;

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_dz_q      <= RST_TRIG_DZ;
			cfg_q.stick_dz <= RST_STICK_DZ;
			cfg_q.press_m  <= RST_PRESS_M;
			cfg_q.rel_m    <= RST_REL_M;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TRIG_DZ:  trig_dz_q      <= cfg_data[7:0];
				CFG_STICK_DZ: cfg_q.stick_dz <= cfg_data;
				CFG_PRESS_M:  cfg_q.press_m  <= cfg_data[7:0];
				CFG_REL_M:    cfg_q.rel_m    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each poll and queues it.
	gic_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.trig_dz  (trig_dz_q),
		.q_vld    (q_vld),
		.q_rdy    (q_rdy),
		.q_rec    (q_rec)
	);

	// The back end works through one queued poll at a time.
	gic_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (q_vld),
		.q_rdy    (q_rdy),
		.q_rec    (q_rec),
		.cfg      (cfg_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {1'b0, res.ry, res.rx, res.ly, res.lx, res.rt, res.lt,
		res.ms, res.frames, res.bidx, res.conn, res.pad};
	assign m_tlast = res.last;
endmodule

// ===== hdl/gic_ram.sv =====
// ----------------------------------------------------------------------------
// gic_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/gic_front.sv =====
// ----------------------------------------------------------------------------
// gic_front: request intake and poll queue
// Accepts polls, applies the trigger dead zone, classifies the pad and holds
// up to two polls for the back end.
// ----------------------------------------------------------------------------
module gic_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [103:0]  s_tdata,
	input  logic [7:0]    trig_dz,
	output logic          q_vld,
	input  logic          q_rdy,
	output gic_pkg::poll_t q_rec
);
	import gic_pkg::*;

	poll_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	poll_t      rec;
	logic       push;
	logic       pop;
	logic [7:0] t0;
	logic [7:0] t1;

	assign t0 = s_tdata[24:17];
	assign t1 = s_tdata[32:25];

	always_comb begin
		rec.pad     = s_tdata[1:0];
		rec.pad_ok  = ((PAD_W+1)'(s_tdata[1:0]) < (PAD_W+1)'(NUM_PADS));
		rec.valid   = s_tdata[2] && rec.pad_ok;
		rec.mask    = s_tdata[16:3];
		rec.trig0   = (t0 < trig_dz) ? 8'd0 : t0;
		rec.trig1   = (t1 < trig_dz) ? 8'd0 : t1;
		rec.lx      = s_tdata[48:33];
		rec.ly      = s_tdata[64:49];
		rec.rx      = s_tdata[80:65];
		rec.ry      = s_tdata[96:81];
		rec.elapsed = s_tdata[103:97];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_vld    = (cnt_q != 2'd0);
	assign pop      = q_vld && q_rdy;
	assign q_rec    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== hdl/gic_stick.sv =====
// ----------------------------------------------------------------------------
// gic_stick: radial dead zone for one stick
// Squares, an iterative square root and a shared bit-serial divider.
// ----------------------------------------------------------------------------
module gic_stick (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] x,
	input  logic signed [15:0] y,
	input  logic [14:0]        dz,
	output logic               done,
	output logic signed [15:0] ox,
	output logic signed [15:0] oy
);
	import gic_pkg::*;

	stk_state_t  state_q, state_d;
	stk_phase_t  phase_q;
	logic [15:0] ax_q, ay_q;
	logic        nx_q, ny_q;
	logic [30:0] fx_q, fy_q;
	logic [61:0] sum_q;
	logic [61:0] n_q;
	logic [62:0] r_q;
	logic [62:0] bit_q;
	logic [4:0]  cnt_q;
	logic        big_q;
	logic [30:0] m_q;
	logic [30:0] g_q;
	logic [61:0] dvd_q;
	logic [31:0] rem_q;
	logic [30:0] dvs_q;
	logic [5:0]  dcnt_q;
	logic [29:0] d_w;
	logic [29:0] dsq;
	logic        zero_hit;
	logic [63:0] trial_r;
	logic        r_take;
	logic [31:0] trial_d;
	logic        d_take;
	logic [61:0] quot;
	logic [46:0] prod;

	// Positive axes: floor(v * 2^30 / 32767) = v * 32769 + (v == 32767)
	function automatic logic [30:0] axis_q30(input logic signed [15:0] v);
		logic [30:0] p;
		begin
			if (v > 16'sd0) begin
				p = 31'(v[14:0]) * 31'd32769;
				axis_q30 = p + 31'(v == 16'sd32767);
			end else begin
				axis_q30 = {16'(-v), 15'd0};
			end
		end
	endfunction

	function automatic logic [15:0] signed_mag(input logic neg, input logic [15:0] mag);
		begin
			signed_mag = neg ? (16'd0 - mag) : mag;
		end
	endfunction

	assign d_w      = {dz, 15'd0};
	assign dsq      = 30'(dz) * 30'(dz);
	assign zero_hit = (sum_q == 62'd0) || (sum_q < {2'b00, dsq, 30'd0});
	assign trial_r  = 64'(r_q) + 64'(bit_q);
	assign r_take   = (64'(n_q) >= trial_r);
	assign trial_d  = {rem_q[30:0], dvd_q[61]};
	assign d_take   = (trial_d >= {1'b0, dvs_q});
	assign quot     = {dvd_q[60:0], d_take};
	assign prod     = ((phase_q == PH_X) ? 47'(ax_q) : 47'(ay_q)) * 47'(g_q);
	assign done     = (state_q == STK_DONE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			STK_IDLE: if (start) state_d = STK_SQX;
			STK_SQX:  state_d = STK_SQY;
			STK_SQY:  state_d = STK_CHK;
			STK_CHK:  state_d = zero_hit ? STK_DONE : STK_ROOT;
			STK_ROOT: if (cnt_q == 5'd0) state_d = STK_SEL;
			STK_SEL:  state_d = STK_DIV;
			STK_DIV: begin
				if (dcnt_q == 6'd0) begin
					case (phase_q)
						PH_G:    state_d = STK_MUL;
						PH_X:    state_d = big_q ? STK_DIV : STK_MUL;
						default: state_d = STK_DONE;
					endcase
				end
			end
			STK_MUL:  state_d = STK_DIV;
			STK_DONE: state_d = STK_IDLE;
			default:  state_d = STK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			STK_IDLE: begin
				if (start) begin
					ax_q <= 16'(x < 0 ? -x : x);
					ay_q <= 16'(y < 0 ? -y : y);
					nx_q <= x[15];
					ny_q <= y[15];
					fx_q <= axis_q30(x);
					fy_q <= axis_q30(y);
				end
			end
			STK_SQX: sum_q <= 62'(fx_q) * 62'(fx_q);
			STK_SQY: sum_q <= sum_q + 62'(fy_q) * 62'(fy_q);
			STK_CHK: begin
				ox    <= 16'sd0;
				oy    <= 16'sd0;
				n_q   <= sum_q;
				r_q   <= 63'd0;
				bit_q <= 63'(1) << 62;
				cnt_q <= 5'd31;
				big_q <= (sum_q > (62'(1) << 60));
			end
			STK_ROOT: begin
				if (r_take) begin
					n_q <= 62'(64'(n_q) - trial_r);
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			STK_SEL: begin
				m_q    <= r_q[30:0];
				rem_q  <= 32'd0;
				dcnt_q <= 6'd61;
				if (big_q) begin
					phase_q <= PH_X;
					dvd_q   <= 62'(ax_q) << 30;
					dvs_q   <= r_q[30:0];
				end else begin
					phase_q <= PH_G;
					dvd_q   <= 62'(r_q[30:0] - 31'(d_w)) << 30;
					dvs_q   <= (31'(1) << 30) - 31'(d_w);
				end
			end
			STK_DIV: begin
				rem_q  <= d_take ? (trial_d - {1'b0, dvs_q}) : trial_d;
				dvd_q  <= quot;
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd0) begin
					case (phase_q)
						PH_G: begin
							g_q     <= quot[30:0];
							dvs_q   <= m_q;
							phase_q <= PH_X;
						end
						PH_X: begin
							ox      <= signed_mag(nx_q, quot[15:0]);
							phase_q <= PH_Y;
							if (big_q) begin
								dvd_q  <= 62'(ay_q) << 30;
								rem_q  <= 32'd0;
								dcnt_q <= 6'd61;
							end
						end
						default: oy <= signed_mag(ny_q, quot[15:0]);
					endcase
				end
			end
			STK_MUL: begin
				dvd_q  <= 62'(prod);
				rem_q  <= 32'd0;
				dcnt_q <= 6'd61;
			end
			default: ;
		endcase
	end
endmodule

// ===== hdl/gic_back.sv =====
// ----------------------------------------------------------------------------
// gic_back: poll execution
// Conditions both sticks of a connected pad, updates hold counters and trigger
// thresholds and issues sixteen results per poll.
// ----------------------------------------------------------------------------
module gic_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_vld,
	output logic              q_rdy,
	input  gic_pkg::poll_t    q_rec,
	input  gic_pkg::back_cfg_t cfg,
	output logic              m_tvalid,
	input  logic              m_tready,
	output gic_pkg::res_t     res
);
	import gic_pkg::*;

	back_state_t        state_q, state_d;
	poll_t              rec_q;
	logic [BTN_W-1:0]   k_q;
	logic [SLOTS-1:0]   vld_q;
	logic               vld_s2;
	logic [7:0]         thr_q [NUM_PADS*2];
	logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
	res_t               out_q;
	logic               stk_start;
	logic               stk_done;
	logic signed [15:0] stk_x, stk_y, stk_ox, stk_oy;
	logic [SLOT_W-1:0]  slot;
	logic [CNT_W-1:0]   rdata;
	logic [CNT_W-1:0]   wdata;
	logic               we;
	logic [7:0]         old_f;
	logic [15:0]        old_ms;
	logic [7:0]         new_f;
	logic [15:0]        new_ms;
	logic [16:0]        ms_sum;
	logic [PAD_W:0]     tidx;
	logic [7:0]         trig;
	logic [7:0]         thr;
	logic               down;
	logic [7:0]         lo;
	logic [8:0]         hi;
	logic [7:0]         thr_new;

	assign slot      = {rec_q.pad, k_q};
	assign tidx      = {rec_q.pad, k_q[0]};
	assign trig      = k_q[0] ? rec_q.trig1 : rec_q.trig0;
	assign thr       = thr_q[tidx];
	assign stk_start = (state_q == B_LGO) || (state_q == B_RGO);
	assign stk_x     = (state_q == B_LGO) ? rec_q.lx : rec_q.rx;
	assign stk_y     = (state_q == B_LGO) ? rec_q.ly : rec_q.ry;
	assign q_rdy     = (state_q == B_IDLE);
	assign m_tvalid  = (state_q == B_OUT);
	assign res       = out_q;

	gic_stick u_stick (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (stk_start),
		.x      (stk_x),
		.y      (stk_y),
		.dz     (cfg.stick_dz),
		.done   (stk_done),
		.ox     (stk_ox),
		.oy     (stk_oy)
	);

	gic_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_cnt_ram (
		.clk   (clk),
		.we    (we),
		.waddr (slot),
		.wdata (wdata),
		.raddr (slot),
		.rdata (rdata)
	);

	always_comb begin
		old_f  = vld_s2 ? rdata[23:16] : 8'd0;
		old_ms = vld_s2 ? rdata[15:0] : 16'd0;
		if (k_q < BTN_W'(2)) begin
			down = rec_q.valid && (trig > thr);
		end else begin
			down = rec_q.valid && rec_q.mask[4'(k_q - BTN_W'(2))];
		end
		ms_sum = 17'(old_ms) + 17'(rec_q.elapsed);
		new_f  = down ? ((old_f == 8'hFF) ? 8'hFF : old_f + 8'd1) : 8'd0;
		new_ms = down ? (ms_sum[16] ? 16'hFFFF : ms_sum[15:0]) : 16'd0;
		wdata  = {new_f, new_ms};
		we     = (state_q == B_UPD) && rec_q.pad_ok;
		lo     = (trig > cfg.press_m) ? (trig - cfg.press_m) : 8'd0;
		hi     = 9'(trig) + 9'(cfg.rel_m);
		if (hi > 9'd255) begin
			hi = 9'd255;
		end
		if (!rec_q.valid) begin
			thr_new = 8'd0;
		end else if (down) begin
			thr_new = (thr <= lo) ? lo : thr;
		end else begin
			thr_new = (9'(thr) >= hi) ? hi[7:0] : thr;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (q_vld) state_d = q_rec.valid ? B_LGO : B_RD;
			B_LGO:   state_d = B_LWT;
			B_LWT:   if (stk_done) state_d = B_RGO;
			B_RGO:   state_d = B_RWT;
			B_RWT:   if (stk_done) state_d = B_RD;
			B_RD:    state_d = B_UPD;
			B_UPD:   state_d = B_OUT;
			B_OUT: begin
				if (m_tready) begin
					state_d = (k_q == {BTN_W{1'b1}}) ? B_IDLE : B_RD;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q     <= '0;
			vld_q   <= '0;
			for (int i = 0; i < NUM_PADS*2; i++) begin
				thr_q[i] <= 8'd0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == B_IDLE) begin
				k_q <= '0;
			end else if (state_q == B_OUT && m_tready) begin
				k_q <= k_q + BTN_W'(1);
			end
			if (we) begin
				vld_q[slot] <= 1'b1;
			end
			if (we && k_q < BTN_W'(2)) begin
				thr_q[tidx] <= thr_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_vld) begin
			rec_q <= q_rec;
			lx_q  <= 16'sd0;
			ly_q  <= 16'sd0;
			rx_q  <= 16'sd0;
			ry_q  <= 16'sd0;
		end
		if (state_q == B_LWT && stk_done) begin
			lx_q <= stk_ox;
			ly_q <= stk_oy;
		end
		if (state_q == B_RWT && stk_done) begin
			rx_q <= stk_ox;
			ry_q <= stk_oy;
		end
		vld_s2 <= vld_q[slot];
		if (state_q == B_UPD) begin
			out_q.pad    <= rec_q.pad;
			out_q.conn   <= rec_q.valid;
			out_q.bidx   <= k_q;
			out_q.frames <= rec_q.valid ? new_f : 8'd0;
			out_q.ms     <= rec_q.valid ? new_ms : 16'd0;
			out_q.lt     <= rec_q.valid ? rec_q.trig0 : 8'd0;
			out_q.rt     <= rec_q.valid ? rec_q.trig1 : 8'd0;
			out_q.lx     <= lx_q;
			out_q.ly     <= ly_q;
			out_q.rx     <= rx_q;
			out_q.ry     <= ry_q;
			out_q.last   <= (k_q == {BTN_W{1'b1}});
		end
	end

`ifndef SYNTHESIS
	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT && out_q.last) |-> (k_q == {BTN_W{1'b1}}))
		else $error("last result flagged on a button other than the final one");
	a_stick_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stk_done |-> (state_q == B_LWT || state_q == B_RWT))
		else $error("stick unit finished while nobody was waiting");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT && !out_q.conn) |-> (out_q.frames == 8'd0 && out_q.ms == 16'd0))
		else $error("disconnected pad reported non-zero hold counters");
`endif
endmodule
